/* rtl/core/gpck_pkg.sv */
package gpck_pkg;

	// Grid geometry and field widths
	localparam int GRID_SIZE    = 32;
	localparam int COORD_W      = 5;
	localparam int ADDR_W       = $clog2(GRID_SIZE);
	localparam int COUNT_W      = 63;
	localparam int KNIGHT_CELLS = 9;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [ADDR_W-1:0]         addr_t;
	typedef logic [COUNT_W-1:0]        count_t;
	typedef logic signed [COORD_W+1:0] diff_t;

	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

	// Row and column offsets of the knight cell and its eight knight moves
	localparam diff_t KNIGHT_DR [KNIGHT_CELLS] = '{
		diff_t'(0), -diff_t'(2), -diff_t'(1), diff_t'(1), diff_t'(2),
		diff_t'(2), diff_t'(1), -diff_t'(1), -diff_t'(2)
	};
	localparam diff_t KNIGHT_DC [KNIGHT_CELLS] = '{
		diff_t'(0), diff_t'(1), diff_t'(2), diff_t'(2), diff_t'(1),
		-diff_t'(1), -diff_t'(2), -diff_t'(2), -diff_t'(1)
	};

	// Everything the cell update needs for one cell
	typedef struct packed {
		coord_t row;
		coord_t col;
		coord_t knight_row;
		coord_t knight_col;
		count_t up;
		count_t left;
	} cell_req_t;

endpackage

/* rtl/core/gpck_row_ram.sv */
module gpck_row_ram (
	input  logic            clk,
	input  logic            we,
	input  gpck_pkg::addr_t waddr,
	input  gpck_pkg::count_t wdata,
	input  gpck_pkg::addr_t raddr,
	output gpck_pkg::count_t rdata
);
	import gpck_pkg::*;

	// One entry per column; holds the counts of the row last written.
	count_t mem [GRID_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/gpck_cell_unit.sv */
module gpck_cell_unit (
	input  gpck_pkg::cell_req_t req,
	output gpck_pkg::count_t    count
);
	import gpck_pkg::*;

	diff_t              dr;
	diff_t              dc;
	logic               blocked;
	count_t             up;
	count_t             left;
	logic [COUNT_W:0]   sum;

	always_comb begin
		dr = $signed({2'b00, req.row}) - $signed({2'b00, req.knight_row});
		dc = $signed({2'b00, req.col}) - $signed({2'b00, req.knight_col});
		blocked = 1'b0;
		for (int k = 0; k < KNIGHT_CELLS; k++) begin
			if (dr == KNIGHT_DR[k] && dc == KNIGHT_DC[k]) begin
				blocked = 1'b1;
			end
		end

		// Neighbours outside the grid contribute nothing.
		up   = (req.row != '0) ? req.up : '0;
		left = (req.col != '0) ? req.left : '0;
		sum  = {1'b0, up} + {1'b0, left};

		if (blocked) begin
			count = '0;
		end else if (req.row == '0 && req.col == '0) begin
			count = count_t'(1);
		end else if (sum[COUNT_W]) begin
			count = COUNT_MAX;
		end else begin
			count = sum[COUNT_W-1:0];
		end
	end

endmodule

/* rtl/core/grid_path_count_with_knight_block.sv */
// Counts the monotone down/right paths from cell (0,0) to a target cell on a
// 32 by 32 grid, avoiding the knight cell and the knight-move cells around it
// that fall inside the grid; counts saturate at 2^63 - 1. One request is
// worked on at a time: after it is accepted the block sweeps every cell of
// the rectangle from (0,0) to the target, one cell per clock, through a
// single row buffer memory. A target outside the grid would answer zero,
// but with 5-bit coordinates every target lies inside it. The result sits
// in an output register, so a new request may be accepted while the
// previous result waits to be taken. The row buffer needs no clearing after
// reset, because the first row of a sweep ignores what it reads and writes
// every entry that a later row of the sweep reads.
module grid_path_count_with_knight_block (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [4:0] target_row, [9:5] target_col, [14:10] knight_row,
	// [19:15] knight_col, [23:20] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [62:0] path_count, [63] zero
	output logic [63:0] m_tdata
);
	import gpck_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t    state_q;
	coord_t    tr_q, tc_q, kr_q, kc_q;
	coord_t    r_q, c_q;
	count_t    result_q;

	// Second stage: the cell whose up-count is being read back this cycle
	logic      valid_s1;
	coord_t    r_s1, c_s1;
	logic      fwd_s1;
	count_t    fwd_data_s1;
	count_t    left_q;

	logic      issue;
	logic      last_issue;
	coord_t    in_tr, in_tc;
	count_t    ram_rdata;
	count_t    cell_count;
	cell_req_t cell_req;

	assign in_tr      = s_tdata[4:0];
	assign in_tc      = s_tdata[9:5];
	assign s_tready   = (state_q == ST_IDLE);
	assign issue      = (state_q == ST_ISSUE);
	assign last_issue = (r_q == tr_q) && (c_q == tc_q);

	// The row buffer returns the entry in the cycle after its address is given.
	// When the target column is zero the cell just above is written in the
	// very cycle it is read, so its value is forwarded around the memory.
	gpck_row_ram u_row_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (addr_t'(c_s1)),
		.wdata (cell_count),
		.raddr (addr_t'(c_q)),
		.rdata (ram_rdata)
	);

	always_comb begin
		cell_req.row        = r_s1;
		cell_req.col        = c_s1;
		cell_req.knight_row = kr_q;
		cell_req.knight_col = kc_q;
		cell_req.up         = fwd_s1 ? fwd_data_s1 : ram_rdata;
		cell_req.left       = left_q;
	end

	gpck_cell_unit u_cell_unit (
		.req   (cell_req),
		.count (cell_count)
	);

	// Sequencer: walks the rectangle row by row and holds the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tr_q     <= '0;
			tc_q     <= '0;
			kr_q     <= '0;
			kc_q     <= '0;
			r_q      <= '0;
			c_q      <= '0;
			result_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
		end else begin
			// A result taken here is replaced in the same cycle when the
			// sequencer has a fresh one ready.
			if (m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						tr_q <= in_tr;
						tc_q <= in_tc;
						kr_q <= s_tdata[14:10];
						kc_q <= s_tdata[19:15];
						r_q  <= '0;
						c_q  <= '0;
						if (int'(in_tr) >= GRID_SIZE || int'(in_tc) >= GRID_SIZE) begin
							result_q <= '0;
							state_q  <= ST_DONE;
						end else begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end else if (c_q == tc_q) begin
						c_q <= '0;
						r_q <= r_q + coord_t'(1);
					end else begin
						c_q <= c_q + coord_t'(1);
					end
				end
				ST_DRAIN: begin
					// The target cell is in the second stage now.
					result_q <= cell_count;
					state_q  <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {1'b0, result_q};
						state_q  <= ST_IDLE;
					end else begin
						m_tvalid <= 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			fwd_s1   <= issue && valid_s1 && (c_s1 == c_q);
		end
	end

	always_ff @(posedge clk) begin
		r_s1        <= r_q;
		c_s1        <= c_q;
		fwd_data_s1 <= cell_count;
		if (valid_s1) begin
			left_q <= cell_count;
		end
	end

	// The second stage only ever holds a cell while a sweep is running.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
		else $error("cell in flight outside a sweep");

	// Forwarding is only needed when the sweep is one column wide.
	assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> (tc_q == '0))
		else $error("forwarding taken on a wide sweep");

	// An accepted request keeps the input closed in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while busy");

	// A result is only presented after the sequencer has finished a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_DONE))
		else $error("result presented without a finished request");

endmodule
